/* rtl/core/mprs_pkg.sv */
// mprs_pkg: shared widths, operation codes, sequencer states and the
// arithmetic unit control type for the multi-producer ring sequencer
// no dependencies
package mprs_pkg;

   localparam int SEQ_W         = 64;
   localparam int POS_W         = 63;
   localparam int COUNT_W       = 11;
   localparam int MARK_W        = 32;
   localparam int OP_W          = 2;
   localparam int DEF_RING_SIZE = 1024;

   localparam logic [OP_W-1:0] OP_CLAIM   = 2'd0;
   localparam logic [OP_W-1:0] OP_PUBLISH = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   typedef struct packed {
      logic sub;
      logic sgn;
   } alu_ctrl_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CL_ADD,
      ST_CL_WRAP,
      ST_CL_CMP_CACHE,
      ST_CL_CMP_CUR,
      ST_CL_REFRESH,
      ST_CL_GRANT,
      ST_PB_DIFF,
      ST_PB_SPAN,
      ST_PB_START,
      ST_PB_WRITE,
      ST_QY_DIFF,
      ST_QY_SPAN,
      ST_QY_READ,
      ST_QY_CHECK,
      ST_QY_MISS,
      ST_RESP
   } state_type;

endpackage

/* rtl/core/mprs_if.sv */
// mprs_req_if and mprs_rsp_if: valid/ready channels of the ring sequencer
// depends on mprs_pkg for field widths
interface mprs_req_if;
   import mprs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [COUNT_W-1:0]       count;
   logic [POS_W-1:0]         first_seq;
   logic [POS_W-1:0]         last_seq;
   logic signed [SEQ_W-1:0]  min_consumer_seq;

   modport source (output valid, op, count, first_seq, last_seq, min_consumer_seq,
                   input ready);
   modport sink   (input valid, op, count, first_seq, last_seq, min_consumer_seq,
                   output ready);
endinterface

interface mprs_rsp_if;
   import mprs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [SEQ_W-1:0]  seq_out;

   modport source (output valid, ok, seq_out, input ready);
   modport sink   (input valid, ok, seq_out, output ready);
endinterface

/* rtl/core/multi_producer_ring_sequencer.sv */
// multi_producer_ring_sequencer: claim / publish / query sequencer over a ring
// of round marks; depends on mprs_pkg, mprs_if, mprs_alu and mprs_mark_ram
//
// Requests arrive on req_chan (valid/ready), one result per request leaves on
// rsp_chan (valid/ready). A transfer happens when valid and ready are both high.
// After reset a clearing pass writes all ones into every ring entry, with
// req_chan.ready held low throughout; cursor and consumer cache reset to -1.
// One request is worked on at a time by a small sequencer driving a single
// 64-bit add/compare unit, so req_chan.ready is high only when idle.
// Work from request transfer to result in the output register:
//   claim    add, wrap, compare, then grant, after a cache refresh when needed;
//            a bad count (also an unused code) goes straight to the result
//   publish  N entries written (at most RING_SIZE), none for an empty range
//   query    a read and check per entry walked, none for an empty range
// The walks are set by the ring memory port: one write per cycle for publish,
// one registered read and compare per entry for query.
// The result sits in an output register; a new request is taken while it waits.
// A stalled receiver holds the result; a finished request then waits for the
// output register to drain before the next request is taken.
module multi_producer_ring_sequencer #(
   parameter int RING_SIZE = mprs_pkg::DEF_RING_SIZE
) (
   input  logic      clock,
   input  logic      reset,
   mprs_req_if.sink  req_chan,
   mprs_rsp_if.source rsp_chan
);
   import mprs_pkg::*;

   localparam int                LOG2    = $clog2(RING_SIZE);
   localparam logic [SEQ_W-1:0]  RS_SEQ  = SEQ_W'(RING_SIZE);
   localparam logic [SEQ_W-1:0]  RS_M1   = SEQ_W'(RING_SIZE - 1);
   localparam logic [SEQ_W-1:0]  ONE_SEQ = SEQ_W'(1);

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   first_ff, first_in;
   logic [POS_W-1:0]   last_ff, last_in;
   logic [SEQ_W-1:0]   minc_ff, minc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SEQ_W-1:0]   cur_ff, cur_in;
   logic [SEQ_W-1:0]   cache_ff, cache_in;
   logic [SEQ_W-1:0]   acc_ff, acc_in;
   logic [POS_W-1:0]   s_ff, s_in;
   logic [LOG2:0]      n_ff, n_in;
   logic               flag_ff, flag_in;
   logic               res_ok_ff, res_ok_in;
   logic [SEQ_W-1:0]   res_seq_ff, res_seq_in;
   logic [LOG2-1:0]    clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;

   alu_ctrl_type       alu_ctrl;
   logic [SEQ_W-1:0]   alu_a, alu_b, alu_sum;
   logic               alu_lt;

   logic               ram_we;
   logic [LOG2-1:0]    ram_waddr, ram_raddr;
   logic [MARK_W-1:0]  ram_wdata, ram_rdata;

   logic               req_fire, rsp_free, count_ok, mark_hit, n_zero;
   logic [SEQ_W-1:0]   s_seq, sum_claim;
   logic [MARK_W-1:0]  s_mark;

   mprs_alu u_alu (
      .ctrl (alu_ctrl),
      .a_in (alu_a),
      .b_in (alu_b),
      .sum  (alu_sum),
      .lt   (alu_lt)
   );

   mprs_mark_ram #(.DEPTH(RING_SIZE)) u_mark_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.ok      = rsp_ok_ff;
   assign rsp_chan.seq_out = rsp_seq_ff;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign count_ok  = (req_chan.count != '0) && (32'(req_chan.count) <= 32'(RING_SIZE));
   assign s_seq     = {1'b0, s_ff};
   assign s_mark    = s_ff[LOG2 +: MARK_W];
   assign mark_hit  = (ram_rdata == s_mark);
   assign n_zero    = (n_ff == '0);
   assign sum_claim = alu_sum;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LOG2'(RING_SIZE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.op)
                  OP_CLAIM:   state_in = count_ok ? ST_CL_ADD : ST_RESP;
                  OP_PUBLISH: state_in = ST_PB_DIFF;
                  OP_QUERY:   state_in = ST_QY_DIFF;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_CL_ADD:       state_in = ST_CL_WRAP;
         ST_CL_WRAP:      state_in = ST_CL_CMP_CACHE;
         ST_CL_CMP_CACHE: state_in = ST_CL_CMP_CUR;
         ST_CL_CMP_CUR:   state_in = (flag_ff || alu_lt) ? ST_CL_REFRESH : ST_CL_GRANT;
         ST_CL_REFRESH:   state_in = alu_lt ? ST_RESP : ST_CL_GRANT;
         ST_CL_GRANT:     state_in = ST_RESP;
         ST_PB_DIFF:      state_in = alu_lt ? ST_RESP : ST_PB_SPAN;
         ST_PB_SPAN:      state_in = alu_lt ? ST_PB_WRITE : ST_PB_START;
         ST_PB_START:     state_in = ST_PB_WRITE;
         ST_PB_WRITE: begin
            if (n_zero) state_in = ST_RESP;
         end
         ST_QY_DIFF:      state_in = alu_lt ? ST_RESP : ST_QY_SPAN;
         ST_QY_SPAN:      state_in = ST_QY_READ;
         ST_QY_READ:      state_in = ST_QY_CHECK;
         ST_QY_CHECK: begin
            priority if (!mark_hit) state_in = ST_QY_MISS;
            else if (n_zero)        state_in = ST_RESP;
            else                    state_in = ST_QY_READ;
         end
         ST_QY_MISS:      state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   // datapath control and register next values
   always_comb begin
      first_in   = first_ff;
      last_in    = last_ff;
      minc_in    = minc_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      cache_in   = cache_ff;
      acc_in     = acc_ff;
      s_in       = s_ff;
      n_in       = n_ff;
      flag_in    = flag_ff;
      res_ok_in  = res_ok_ff;
      res_seq_in = res_seq_ff;
      clr_in     = clr_ff;
      alu_ctrl   = '{sub: 1'b0, sgn: 1'b0};
      alu_a      = cur_ff;
      alu_b      = '0;
      ram_we     = 1'b0;
      ram_waddr  = s_ff[LOG2-1:0];
      ram_wdata  = s_mark;
      ram_raddr  = s_ff[LOG2-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '1;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               first_in   = req_chan.first_seq;
               last_in    = req_chan.last_seq;
               minc_in    = req_chan.min_consumer_seq;
               count_in   = req_chan.count;
               res_ok_in  = 1'b0;
               res_seq_in = '1;
            end
         end
         ST_CL_ADD: begin
            alu_a  = cur_ff;
            alu_b  = SEQ_W'(count_ff);
            acc_in = alu_sum;
         end
         ST_CL_WRAP: begin
            alu_ctrl = '{sub: 1'b1, sgn: 1'b0};
            alu_a    = acc_ff;
            alu_b    = RS_SEQ;
            acc_in   = alu_sum;
         end
         ST_CL_CMP_CACHE: begin
            // wrap point beyond the cached minimum
            alu_ctrl = '{sub: 1'b1, sgn: 1'b1};
            alu_a    = cache_ff;
            alu_b    = acc_ff;
            flag_in  = alu_lt;
         end
         ST_CL_CMP_CUR: begin
            // cache ahead of the cursor
            alu_ctrl = '{sub: 1'b1, sgn: 1'b1};
            alu_a    = cur_ff;
            alu_b    = cache_ff;
         end
         ST_CL_REFRESH: begin
            alu_ctrl = '{sub: 1'b1, sgn: 1'b1};
            alu_a    = minc_ff;
            alu_b    = acc_ff;
            cache_in = minc_ff;
         end
         ST_CL_GRANT: begin
            alu_a      = cur_ff;
            alu_b      = SEQ_W'(count_ff);
            cur_in     = sum_claim;
            res_ok_in  = 1'b1;
            res_seq_in = sum_claim;
         end
         ST_PB_DIFF: begin
            alu_ctrl = '{sub: 1'b1, sgn: 1'b0};
            alu_a    = {1'b0, last_ff};
            alu_b    = {1'b0, first_ff};
            acc_in   = alu_sum;
            res_ok_in  = 1'b1;
            res_seq_in = '0;
         end
         ST_PB_SPAN: begin
            alu_ctrl = '{sub: 1'b1, sgn: 1'b0};
            alu_a    = acc_ff;
            alu_b    = RS_SEQ;
            s_in     = first_ff;
            n_in     = {1'b0, acc_ff[LOG2-1:0]};
         end
         ST_PB_START: begin
            // long range: only the last ring's worth of sequences survives
            alu_ctrl = '{sub: 1'b1, sgn: 1'b0};
            alu_a    = {1'b0, last_ff};
            alu_b    = RS_M1;
            s_in     = alu_sum[POS_W-1:0];
            n_in     = (LOG2+1)'(RING_SIZE - 1);
         end
         ST_PB_WRITE: begin
            ram_we = 1'b1;
            alu_a  = s_seq;
            alu_b  = ONE_SEQ;
            if (!n_zero) begin
               s_in = alu_sum[POS_W-1:0];
               n_in = n_ff - 1'b1;
            end
         end
         ST_QY_DIFF: begin
            alu_ctrl   = '{sub: 1'b1, sgn: 1'b0};
            alu_a      = {1'b0, last_ff};
            alu_b      = {1'b0, first_ff};
            acc_in     = alu_sum;
            res_ok_in  = 1'b1;
            res_seq_in = {1'b0, last_ff};
         end
         ST_QY_SPAN: begin
            alu_ctrl = '{sub: 1'b1, sgn: 1'b0};
            alu_a    = RS_SEQ;
            alu_b    = acc_ff;
            s_in     = first_ff;
            n_in     = alu_lt ? (LOG2+1)'(RING_SIZE) : acc_ff[LOG2:0];
         end
         ST_QY_READ: begin
            ram_raddr = s_ff[LOG2-1:0];
         end
         ST_QY_CHECK: begin
            alu_a = s_seq;
            alu_b = ONE_SEQ;
            if (mark_hit && !n_zero) begin
               s_in = alu_sum[POS_W-1:0];
               n_in = n_ff - 1'b1;
            end
         end
         ST_QY_MISS: begin
            alu_ctrl   = '{sub: 1'b1, sgn: 1'b0};
            alu_a      = s_seq;
            alu_b      = ONE_SEQ;
            res_seq_in = alu_sum;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_seq_in   = rsp_seq_ff;
      priority if (state_ff == ST_RESP && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_seq_in   = res_seq_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '1;
         cache_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         cache_ff     <= cache_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff   <= first_in;
      last_ff    <= last_in;
      minc_ff    <= minc_in;
      count_ff   <= count_in;
      acc_ff     <= acc_in;
      s_ff       <= s_in;
      n_ff       <= n_in;
      flag_ff    <= flag_in;
      res_ok_ff  <= res_ok_in;
      res_seq_ff <= res_seq_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_seq_ff <= rsp_seq_in;
   end

   // a transfer always starts work, so the sequencer leaves idle
   a_fire_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after a request transfer");

   // the cursor moves only when a claim is granted
   a_cursor_only_on_grant: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CL_GRANT |=> $stable(cur_ff))
      else $error("cursor changed outside a claim grant");

   // a finished request waits while the receiver stalls a full output register
   a_resp_waits_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_chan.valid && !rsp_chan.ready) |=>
      (state_ff == ST_RESP && $stable(rsp_seq_ff)))
      else $error("result lost while the receiver stalled");

endmodule

/* rtl/core/mprs_alu.sv */
// mprs_alu: shared 64-bit add/subtract unit with signed or unsigned less-than
// depends on mprs_pkg
module mprs_alu (
   input  mprs_pkg::alu_ctrl_type         ctrl,
   input  logic [mprs_pkg::SEQ_W-1:0]     a_in,
   input  logic [mprs_pkg::SEQ_W-1:0]     b_in,
   output logic [mprs_pkg::SEQ_W-1:0]     sum,
   output logic                           lt
);
   import mprs_pkg::*;

   logic [SEQ_W-1:0] flip;
   logic [SEQ_W-1:0] a_x;
   logic [SEQ_W-1:0] b_x;
   logic [SEQ_W:0]   total;

   // signed compare: bias both operands by the sign bit, difference is unchanged
   assign flip  = {ctrl.sgn, {(SEQ_W-1){1'b0}}};
   assign a_x   = a_in ^ flip;
   assign b_x   = ctrl.sub ? ~(b_in ^ flip) : b_in;
   assign total = {1'b0, a_x} + {1'b0, b_x} + {{SEQ_W{1'b0}}, ctrl.sub};
   assign sum   = total[SEQ_W-1:0];
   assign lt    = ctrl.sub & ~total[SEQ_W];

endmodule

/* rtl/core/mprs_mark_ram.sv */
// mprs_mark_ram: round mark store, one write and one registered read per cycle
// depends on mprs_pkg for the mark width
module mprs_mark_ram #(
   parameter  int DEPTH  = mprs_pkg::DEF_RING_SIZE,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mprs_pkg::MARK_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [mprs_pkg::MARK_W-1:0] rd_data
);
   import mprs_pkg::*;

   logic [MARK_W-1:0] mem [DEPTH];
   logic [MARK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/multi_producer_ring_sequencer_test.sv */
// multi_producer_ring_sequencer_test: drives claim, publish and query requests
// and checks every result against a scoreboard that tracks cursor, cache and marks
// depends on mprs_pkg, mprs_if and multi_producer_ring_sequencer
module multi_producer_ring_sequencer_test;
   import mprs_pkg::*;

   localparam int RING       = DEF_RING_SIZE;
   localparam int RING_SHIFT = $clog2(DEF_RING_SIZE);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   first_seq;
      logic [POS_W-1:0]   last_seq;
      logic [SEQ_W-1:0]   min_seq;
   } ring_req_type;

   typedef struct packed {
      logic             ok;
      logic [SEQ_W-1:0] seq;
   } ring_rsp_type;

   class sequencer_scoreboard;
      logic [SEQ_W-1:0]  cursor;
      logic [SEQ_W-1:0]  consumer_cache;
      logic [MARK_W-1:0] marks [RING];
      ring_rsp_type      pending_results [$];
      int                mismatches;

      function new();
         cursor         = '1;
         consumer_cache = '1;
         foreach (marks[i]) marks[i] = '1;
         mismatches     = 0;
      endfunction

      function void note_request(ring_req_type r);
         ring_rsp_type     res;
         logic [SEQ_W-1:0] wrap;
         logic [POS_W-1:0] pos;
         logic [POS_W-1:0] span;
         logic [POS_W-1:0] stop;
         logic             grant;
         res.ok  = 1'b0;
         res.seq = '1;
         case (r.op)
            OP_CLAIM: begin
               if (r.count != 0 && r.count <= RING) begin
                  wrap  = cursor + SEQ_W'(r.count) - SEQ_W'(RING);
                  grant = 1'b1;
                  // refresh when the wrap point passes the cache or the cache runs ahead
                  if ($signed(wrap) > $signed(consumer_cache) ||
                      $signed(consumer_cache) > $signed(cursor)) begin
                     consumer_cache = r.min_seq;
                     grant = !($signed(wrap) > $signed(r.min_seq));
                  end
                  if (grant) begin
                     cursor  = cursor + SEQ_W'(r.count);
                     res.ok  = 1'b1;
                     res.seq = cursor;
                  end
               end
            end
            OP_PUBLISH: begin
               res.ok  = 1'b1;
               res.seq = '0;
               if (r.first_seq <= r.last_seq) begin
                  span = r.last_seq - r.first_seq;
                  // only the last ring's worth of a long range survives
                  if (span >= RING) span = POS_W'(RING - 1);
                  pos = r.last_seq - span;
                  forever begin
                     marks[pos[RING_SHIFT-1:0]] = MARK_W'(pos >> RING_SHIFT);
                     if (pos == r.last_seq) break;
                     pos++;
                  end
               end
            end
            OP_QUERY: begin
               res.ok  = 1'b1;
               res.seq = SEQ_W'(r.last_seq);
               if (r.first_seq <= r.last_seq) begin
                  stop = (r.last_seq - r.first_seq > RING) ? r.first_seq + POS_W'(RING)
                                                           : r.last_seq;
                  pos = r.first_seq;
                  forever begin
                     if (marks[pos[RING_SHIFT-1:0]] != MARK_W'(pos >> RING_SHIFT)) begin
                        res.seq = SEQ_W'(pos) - 1;
                        break;
                     end
                     if (pos == stop) break;
                     pos++;
                  end
               end
            end
            default: ;
         endcase
         pending_results.push_back(res);
      endfunction

      function void check_result(logic ok, logic [SEQ_W-1:0] seq);
         ring_rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: ok=%0b seq=%0d", ok, $signed(seq));
            return;
         end
         want = pending_results.pop_front();
         if (ok !== want.ok || seq !== want.seq) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected ok=%0b seq=%0d, got ok=%0b seq=%0d",
                        want.ok, $signed(want.seq), ok, $signed(seq));
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int ITEMS           = 1600;
   localparam int CALM_ITEMS      = 200;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 50;
   localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
   localparam logic [POS_W-1:0] POS_MAX   = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   sender_idles     = 1'b1;
   bit   receiver_idles   = 1'b1;
   bit   pressure_request = 1'b0;
   int   quiet_cycles     = 0;

   sequencer_scoreboard ring_sb = new();
   logic [POS_W-1:0]    open_first_q [$];
   logic [POS_W-1:0]    open_last_q [$];

   mprs_req_if req_chan ();
   mprs_rsp_if rsp_chan ();

   multi_producer_ring_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic ring_req_type make_req(input logic [OP_W-1:0] op,
                                             input int unsigned count,
                                             input logic [POS_W-1:0] first_seq,
                                             input logic [POS_W-1:0] last_seq,
                                             input logic [SEQ_W-1:0] min_seq);
      ring_req_type r;
      r.op        = op;
      r.count     = COUNT_W'(count);
      r.first_seq = first_seq;
      r.last_seq  = last_seq;
      r.min_seq   = min_seq;
      return r;
   endfunction

   function automatic logic [SEQ_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      return POS_W'({$urandom, $urandom});
   endfunction

   task automatic send_item(input ring_req_type r);
      int gap;
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.op               <= r.op;
      req_chan.count            <= r.count;
      req_chan.first_seq        <= r.first_seq;
      req_chan.last_seq         <= r.last_seq;
      req_chan.min_consumer_seq <= r.min_seq;
      req_chan.valid            <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      ring_sb.note_request(r);
   endtask

   // claim a run of slots with a consumer at or behind the cursor
   task automatic claim_slots();
      logic [SEQ_W-1:0] prior;
      logic [SEQ_W-1:0] minc;
      int unsigned      n;
      prior = ring_sb.cursor;
      n     = ($urandom_range(0, 19) == 0) ? $urandom_range(1, RING) : $urandom_range(1, 16);
      minc  = ($urandom_range(0, 7) == 0) ? prior : prior - $urandom_range(0, 1100);
      send_item(make_req(OP_CLAIM, n, rand_pos(), rand_pos(), minc));
      if (ring_sb.cursor != prior) begin
         open_first_q.push_back(POS_W'(prior + 1));
         open_last_q.push_back(ring_sb.cursor[POS_W-1:0]);
         if (open_first_q.size() > 64) begin
            void'(open_first_q.pop_front());
            void'(open_last_q.pop_front());
         end
      end
   endtask

   initial begin : ready_driver
      int hold;
      rsp_chan.ready = 1'b0;
      forever begin
         hold = 0;
         if (pressure_request) begin
            pressure_request = 1'b0;
            hold = PRESSURE_CYCLES;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 12);
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else begin
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         ring_sb.check_result(rsp_chan.ok, rsp_chan.seq_out);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [POS_W-1:0] cur;
      int               pick;
      int               idx;
      req_chan.valid            = 1'b0;
      req_chan.op               = OP_CLAIM;
      req_chan.count            = '0;
      req_chan.first_seq        = '0;
      req_chan.last_seq         = '0;
      req_chan.min_consumer_seq = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: fresh ring, bad counts, unused code, refusals and ring extremes
      send_item(make_req(OP_QUERY, 1, 0, 5, '1));
      send_item(make_req(OP_CLAIM, 0, 0, 0, '1));
      send_item(make_req(OP_CLAIM, 2047, POS_MAX, POS_MAX, '1));
      send_item(make_req(OP_CLAIM, RING + 1, 0, 0, '1));
      send_item(make_req(OP_UNUSED, 1, 3, 7, '0));
      send_item(make_req(OP_CLAIM, 1, 0, 0, '1));
      send_item(make_req(OP_CLAIM, RING, 0, 0, '1));
      send_item(make_req(OP_CLAIM, RING, 0, 0, '0));
      send_item(make_req(OP_PUBLISH, 1, 0, POS_W'(RING), '0));
      send_item(make_req(OP_QUERY, 1, 0, POS_W'(RING), '0));
      send_item(make_req(OP_QUERY, 1, 1, POS_W'(RING), '0));
      send_item(make_req(OP_PUBLISH, 1, 5, 3, '0));
      send_item(make_req(OP_QUERY, 1, 9, 2, '0));
      send_item(make_req(OP_QUERY, 1, 1, 5000, '0));
      send_item(make_req(OP_CLAIM, RING, 0, 0, SEQ_W'(POS_MAX)));
      send_item(make_req(OP_CLAIM, 1, 0, 0, 64'd2047));
      send_item(make_req(OP_CLAIM, RING, 0, 0, 64'h8000_0000_0000_0000));
      send_item(make_req(OP_PUBLISH, 1, POS_MAX - POS_W'(RING - 1), POS_MAX, '0));
      send_item(make_req(OP_QUERY, 1, POS_MAX - POS_W'(RING - 1), POS_MAX, '0));
      send_item(make_req(OP_PUBLISH, 1, POS_MAX, POS_MAX, '0));
      send_item(make_req(OP_QUERY, 1, POS_MAX, POS_MAX, '0));
      send_item(make_req(OP_PUBLISH, 1, 0, POS_MAX, '0));
      send_item(make_req(OP_QUERY, 1, 0, POS_MAX, '0));

      for (int i = 0; i < ITEMS; i++) begin
         if (i == ITEMS / 2) pressure_request = 1'b1;
         if (i == ITEMS - CALM_ITEMS) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         cur  = ring_sb.cursor[POS_W-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // producers claim, publish out of order and poll the published mark
            case ($urandom_range(0, 2))
               1: begin
                  if (open_first_q.size() != 0) begin
                     idx = $urandom_range(0, open_first_q.size() - 1);
                     send_item(make_req(OP_PUBLISH, $urandom_range(1, RING),
                                        open_first_q[idx], open_last_q[idx], rand_word()));
                     open_first_q.delete(idx);
                     open_last_q.delete(idx);
                  end else begin
                     claim_slots();
                  end
               end
               2: begin
                  lo = (cur < 40) ? '0 : cur - $urandom_range(0, 40);
                  hi = ($urandom_range(0, 29) == 0) ? lo + $urandom_range(RING - 8, RING + 8)
                                                   : lo + $urandom_range(0, 48);
                  send_item(make_req(OP_QUERY, $urandom_range(1, RING), lo, hi, rand_word()));
               end
               default: claim_slots();
            endcase
         end else if (pick < 85) begin
            lo = rand_pos();
            hi = $urandom_range(0, 1) ? rand_pos() : lo + $urandom_range(0, 20);
            send_item(make_req(OP_W'($urandom_range(0, 3)), $urandom_range(0, 2047), lo, hi,
                               rand_word()));
         end else begin
            case ($urandom_range(0, 3))
               0: send_item(make_req(OP_CLAIM,
                                     $urandom_range(0, 1) ? 0 : $urandom_range(RING + 1, 2047),
                                     rand_pos(), rand_pos(), rand_word()));
               1: begin
                  hi = rand_pos() >> 1;
                  lo = hi + $urandom_range(1, 50);
                  send_item(make_req($urandom_range(0, 1) ? OP_PUBLISH : OP_QUERY, 1,
                                     lo, hi, rand_word()));
               end
               2: begin
                  // publish ahead of anything claimed
                  lo = cur + $urandom_range(1, 3000);
                  hi = lo + $urandom_range(0, 20);
                  send_item(make_req(OP_PUBLISH, 1, lo, hi, rand_word()));
               end
               default: begin
                  lo = (cur < 5) ? '0 : cur - 5;
                  hi = cur + $urandom_range(1, 30);
                  send_item(make_req($urandom_range(0, 1) ? OP_QUERY : OP_UNUSED, 1,
                                     lo, hi, rand_word()));
               end
            endcase
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (ring_sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ring_sb.mismatches == 0 && ring_sb.pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/core/mprs_pkg.sv
rtl/core/mprs_if.sv
rtl/core/mprs_alu.sv
rtl/core/mprs_mark_ram.sv
rtl/core/multi_producer_ring_sequencer.sv
tb/sv/multi_producer_ring_sequencer_test.sv
